### src/kt_pkg.sv
// Shared types, constants and saturation helpers for the Kalman tracker.
package kt_pkg;

  localparam int AXES      = 3;
  localparam int EST_W     = 32;
  localparam int COV_W     = 48;
  localparam int DEN_W     = COV_W + 1;
  localparam int PROD_W    = 2 * COV_W;
  localparam int EST_SUM_W = COV_W + 1;
  localparam int COV_SUM_W = COV_W + 3;
  localparam int DT_W      = 21;
  localparam int STD_W     = 25;
  localparam int CFG_IDX_W = 2;
  localparam int Y_W       = EST_W + 1;
  localparam int GATE_W    = 32;
  localparam int GSUM_W    = COV_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_STD  = 2'd2;

  localparam logic [DT_W-1:0]  DT_RESET  = 21'd6554;
  localparam logic [STD_W-1:0] STD_RESET = 25'd65536;

  localparam logic signed [COV_W-1:0] PP_RESET = 48'sd65536;
  localparam logic signed [COV_W-1:0] VV_INIT  = 48'sd655360;

  typedef enum logic [1:0] {CMD_INIT, CMD_PREDICT, CMD_UPDATE, CMD_GATE} cmd_t;
  typedef enum logic [1:0] {SH_NONE, SH_16, SH_17, SH_18} shift_t;

  typedef struct packed {
    logic                    start;
    logic signed [COV_W-1:0] a;
    logic signed [COV_W-1:0] b;
    shift_t                  sh;
    logic                    dv;
    logic [DEN_W-1:0]        den;
  } scale_req_t;

  typedef struct packed {
    logic                    done;
    logic                    clamp;
    logic signed [COV_W-1:0] value;
  } scale_rsp_t;

  typedef struct packed {
    logic                    start;
    cmd_t                    cmd;
    logic [DT_W-1:0]         t;
    logic [STD_W-1:0]        acc;
    logic signed [COV_W-1:0] r;
    logic signed [COV_W-1:0] pp;
    logic signed [COV_W-1:0] pv;
    logic [DEN_W-1:0]        s;
  } job_t;

  function automatic logic ovf_est(input logic signed [EST_SUM_W-1:0] v);
    return !((&v[EST_SUM_W-1:EST_W-1]) || !(|v[EST_SUM_W-1:EST_W-1]));
  endfunction

  function automatic logic signed [EST_W-1:0] sat_est(input logic signed [EST_SUM_W-1:0] v);
    logic signed [EST_W-1:0] r;
    if (ovf_est(v)) r = v[EST_SUM_W-1] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
    else r = v[EST_W-1:0];
    return r;
  endfunction

  function automatic logic ovf_cov(input logic signed [COV_SUM_W-1:0] v);
    return !((&v[COV_SUM_W-1:COV_W-1]) || !(|v[COV_SUM_W-1:COV_W-1]));
  endfunction

  function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [COV_SUM_W-1:0] v);
    logic signed [COV_W-1:0] r;
    if (ovf_cov(v)) r = v[COV_SUM_W-1] ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
    else r = v[COV_W-1:0];
    return r;
  endfunction

endpackage

### src/kt_scale.sv
// Sequential scaled multiply: round(a*b / 2^s) or round(a*b / d), clamped to 48 bits.
module kt_scale import kt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  scale_req_t req,
  output scale_rsp_t rsp
);

  localparam int CNT_W = 7;
  localparam logic [PROD_W-1:0] MAG_MAX = PROD_W'((64'd1 << (COV_W - 1)) - 64'd1);
  localparam logic [PROD_W-1:0] MAG_NEG = PROD_W'(64'd1 << (COV_W - 1));

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_RND, ST_DIV, ST_DRND, ST_FIN} state_t;

  state_t             state;
  logic [COV_W-1:0]   ma, mb;
  logic               neg, dv;
  shift_t             sh;
  logic [DEN_W-1:0]   den;
  logic [PROD_W-1:0]  prod, quo;
  logic [DEN_W-1:0]   rem;
  logic [CNT_W-1:0]   cnt;

  logic [2*COV_W/3+COV_W-1:0] part;
  logic [PROD_W-1:0]  part_sh, prod_rnd, mag, top;
  logic [DEN_W:0]     rem_sh;
  logic               rem_ge, rem_up, over;

  always_comb begin
    part    = ma * mb[15:0];
    part_sh = PROD_W'(part) << {cnt[1:0], 4'b0};
    case (sh)
      SH_16:   prod_rnd = (prod + PROD_W'(1 << 15)) >> 16;
      SH_17:   prod_rnd = (prod + PROD_W'(1 << 16)) >> 17;
      SH_18:   prod_rnd = (prod + PROD_W'(1 << 17)) >> 18;
      default: prod_rnd = prod;
    endcase
    rem_sh = {rem, prod[PROD_W-1]};
    rem_ge = rem_sh >= {1'b0, den};
    rem_up = {rem, 1'b0} >= {1'b0, den};
    top    = neg ? MAG_NEG : MAG_MAX;
    over   = quo > top;
    mag    = over ? top : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            ma    <= req.a[COV_W-1] ? COV_W'(-req.a) : COV_W'(req.a);
            mb    <= req.b[COV_W-1] ? COV_W'(-req.b) : COV_W'(req.b);
            neg   <= req.a[COV_W-1] ^ req.b[COV_W-1];
            sh    <= req.sh;
            dv    <= req.dv;
            den   <= req.den;
            prod  <= '0;
            cnt   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          // one 16-bit slice of b per cycle
          prod <= prod + part_sh;
          mb   <= mb >> 16;
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(2)) state <= ST_RND;
        end
        ST_RND: begin
          prod <= prod_rnd;
          quo  <= prod_rnd;
          rem  <= '0;
          cnt  <= CNT_W'(PROD_W - 1);
          state <= dv ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          prod <= prod << 1;
          rem  <= rem_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
          quo  <= {quo[PROD_W-2:0], rem_ge};
          cnt  <= cnt - CNT_W'(1);
          if (cnt == '0) state <= ST_DRND;
        end
        ST_DRND: begin
          quo   <= quo + PROD_W'(rem_up);
          state <= ST_FIN;
        end
        ST_FIN: begin
          rsp.value <= neg ? -mag[COV_W-1:0] : mag[COV_W-1:0];
          rsp.clamp <= over;
          rsp.done  <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/kt_lane.sv
// One axis lane: position and velocity of one axis, with its own scale unit.
module kt_lane import kt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  job_t                    job,
  input  logic signed [EST_W-1:0] z,
  output logic signed [EST_W-1:0] pos,
  output logic signed [EST_W-1:0] vel,
  output logic [COV_W-1:0]        term,
  output logic                    flag,
  output logic                    busy
);

  typedef enum logic [1:0] {L_IDLE, L_A, L_B} state_t;

  state_t                  state;
  cmd_t                    cmd;
  logic signed [Y_W-1:0]   y, y_now;
  logic signed [COV_W-1:0] pv, yb;
  scale_req_t              sreq;
  scale_rsp_t              srsp;
  logic signed [EST_SUM_W-1:0] pos_sum, vel_sum;

  kt_scale u_scale (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  always_comb begin
    y_now   = {z[EST_W-1], z} - {pos[EST_W-1], pos};
    yb      = COV_W'(y);
    pos_sum = EST_SUM_W'(pos) + EST_SUM_W'(srsp.value);
    vel_sum = EST_SUM_W'(vel) + EST_SUM_W'(srsp.value);
  end

  assign busy = (state != L_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= L_IDLE;
      pos        <= '0;
      vel        <= '0;
      flag       <= 1'b0;
      term       <= '0;
      sreq.start <= 1'b0;
    end else begin
      sreq.start <= 1'b0;
      case (state)
        L_IDLE: begin
          if (job.start) begin
            cmd      <= job.cmd;
            pv       <= job.pv;
            y        <= y_now;
            flag     <= 1'b0;
            term     <= '0;
            sreq.den <= job.s;
            case (job.cmd)
              CMD_INIT: begin
                pos <= '0;
                vel <= '0;
              end
              CMD_PREDICT: begin
                sreq.a     <= COV_W'(signed'({1'b0, job.t}));
                sreq.b     <= COV_W'(vel);
                sreq.sh    <= SH_16;
                sreq.dv    <= 1'b0;
                sreq.start <= 1'b1;
                state      <= L_A;
              end
              CMD_UPDATE: begin
                sreq.a     <= job.pp;
                sreq.b     <= COV_W'(y_now);
                sreq.sh    <= SH_NONE;
                sreq.dv    <= 1'b1;
                sreq.start <= 1'b1;
                state      <= L_A;
              end
              CMD_GATE: begin
                sreq.a     <= COV_W'(y_now);
                sreq.b     <= COV_W'(y_now);
                sreq.sh    <= SH_NONE;
                sreq.dv    <= 1'b1;
                sreq.start <= 1'b1;
                state      <= L_A;
              end
              default: ;
            endcase
          end
        end
        L_A: begin
          if (srsp.done) begin
            case (cmd)
              CMD_PREDICT, CMD_UPDATE: begin
                pos  <= sat_est(pos_sum);
                flag <= flag | srsp.clamp | ovf_est(pos_sum);
              end
              default: begin
                term <= COV_W'(srsp.value);
                flag <= flag | srsp.clamp;
              end
            endcase
            if (cmd == CMD_UPDATE) begin
              // velocity gain uses the same innovation
              sreq.a     <= pv;
              sreq.b     <= yb;
              sreq.start <= 1'b1;
              state      <= L_B;
            end else begin
              state <= L_IDLE;
            end
          end
        end
        L_B: begin
          if (srsp.done) begin
            vel   <= sat_est(vel_sum);
            flag  <= flag | srsp.clamp | ovf_est(vel_sum);
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

### src/kt_cov.sv
// Shared covariance [pp pv; pv vv]: sequenced through one scale unit.
module kt_cov import kt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  job_t                    job,
  output logic signed [COV_W-1:0] pp,
  output logic signed [COV_W-1:0] pv,
  output logic                    flag,
  output logic                    busy
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_COMMIT} state_t;
  typedef enum logic [3:0] {
    OP_Q, OP_T2, OP_T3, OP_T4, OP_TPV, OP_T2VV, OP_TVV,
    OP_A1, OP_A2, OP_A3, OP_NPP, OP_NPV, OP_PPV
  } op_t;
  localparam int OPS = 13;

  state_t                  state;
  op_t                     op;
  cmd_t                    cmd;
  logic                    go;
  logic signed [COV_W-1:0] vv, r, tt, aa;
  logic [DEN_W-1:0]        s;
  logic signed [COV_W-1:0] tmp [OPS];
  scale_req_t              sreq;
  scale_rsp_t              srsp;
  logic signed [COV_SUM_W-1:0] npp, npv, nvv, uvv;

  kt_scale u_scale (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  always_comb begin
    sreq.start = go;
    sreq.den   = s;
    sreq.sh    = SH_16;
    sreq.dv    = 1'b0;
    sreq.a     = tt;
    sreq.b     = tt;
    case (op)
      OP_Q:    begin sreq.a = aa;          sreq.b = aa;          end
      OP_T2:   begin sreq.a = tt;          sreq.b = tt;          end
      OP_T3:   begin sreq.a = tmp[OP_T2];  sreq.b = tt;          end
      OP_T4:   begin sreq.a = tmp[OP_T2];  sreq.b = tmp[OP_T2];  end
      OP_TPV:  begin sreq.a = tt;          sreq.b = pv;          end
      OP_T2VV: begin sreq.a = tmp[OP_T2];  sreq.b = vv;          end
      OP_TVV:  begin sreq.a = tt;          sreq.b = vv;          end
      OP_A1:   begin sreq.a = tmp[OP_T4];  sreq.b = tmp[OP_Q]; sreq.sh = SH_18; end
      OP_A2:   begin sreq.a = tmp[OP_T3];  sreq.b = tmp[OP_Q]; sreq.sh = SH_17; end
      OP_A3:   begin sreq.a = tmp[OP_T2];  sreq.b = tmp[OP_Q];   end
      OP_NPP:  begin sreq.a = pp; sreq.b = r;  sreq.sh = SH_NONE; sreq.dv = 1'b1; end
      OP_NPV:  begin sreq.a = pv; sreq.b = r;  sreq.sh = SH_NONE; sreq.dv = 1'b1; end
      OP_PPV:  begin sreq.a = pv; sreq.b = pv; sreq.sh = SH_NONE; sreq.dv = 1'b1; end
      default: ;
    endcase
    npp = COV_SUM_W'(pp) + (COV_SUM_W'(tmp[OP_TPV]) <<< 1) + COV_SUM_W'(tmp[OP_T2VV])
        + COV_SUM_W'(tmp[OP_A1]);
    npv = COV_SUM_W'(pv) + COV_SUM_W'(tmp[OP_TVV]) + COV_SUM_W'(tmp[OP_A2]);
    nvv = COV_SUM_W'(vv) + COV_SUM_W'(tmp[OP_A3]);
    uvv = COV_SUM_W'(vv) - COV_SUM_W'(tmp[OP_PPV]);
  end

  assign busy = (state != C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      go    <= 1'b0;
      flag  <= 1'b0;
      pp    <= PP_RESET;
      pv    <= '0;
      vv    <= VV_INIT;
    end else begin
      go <= 1'b0;
      case (state)
        C_IDLE: begin
          if (job.start) begin
            cmd  <= job.cmd;
            tt   <= COV_W'(signed'({1'b0, job.t}));
            aa   <= COV_W'(signed'({1'b0, job.acc}));
            r    <= job.r;
            s    <= job.s;
            flag <= 1'b0;
            case (job.cmd)
              CMD_INIT: begin
                pp <= job.r;
                pv <= '0;
                vv <= VV_INIT;
              end
              CMD_PREDICT: begin
                op    <= OP_Q;
                go    <= 1'b1;
                state <= C_RUN;
              end
              CMD_UPDATE: begin
                op    <= OP_NPP;
                go    <= 1'b1;
                state <= C_RUN;
              end
              default: ;
            endcase
          end
        end
        C_RUN: begin
          if (srsp.done) begin
            tmp[op] <= srsp.value;
            flag    <= flag | srsp.clamp;
            if (op == OP_A3 || op == OP_PPV) begin
              state <= C_COMMIT;
            end else begin
              op <= op_t'(op + 4'd1);
              go <= 1'b1;
            end
          end
        end
        C_COMMIT: begin
          if (cmd == CMD_PREDICT) begin
            pp   <= sat_cov(npp);
            pv   <= sat_cov(npv);
            vv   <= sat_cov(nvv);
            flag <= flag | ovf_cov(npp) | ovf_cov(npv) | ovf_cov(nvv);
          end else begin
            pp   <= tmp[OP_NPP];
            pv   <= tmp[OP_NPV];
            vv   <= sat_cov(uvv);
            flag <= flag | ovf_cov(uvv);
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### src/kt_merge.sv
// Merge lane results: gate distance sum with clamp, and the saturation flag.
module kt_merge import kt_pkg::*; (
  input  cmd_t                        cmd,
  input  logic                        bypass,
  input  logic [AXES-1:0][COV_W-1:0]  terms,
  input  logic [AXES-1:0]             lane_flags,
  input  logic                        cov_flag,
  output logic [GATE_W-1:0]           gate,
  output logic                        sat
);

  logic [GSUM_W-1:0] sum;
  logic              over;

  always_comb begin
    sum = '0;
    for (int i = 0; i < AXES; i++) sum = sum + GSUM_W'(terms[i]);
    over = (sum > GSUM_W'({GATE_W{1'b1}}));
    if (bypass) begin
      // innovation variance not positive: refuse the command
      gate = (cmd == CMD_GATE) ? {GATE_W{1'b1}} : '0;
      sat  = 1'b1;
    end else begin
      gate = over ? {GATE_W{1'b1}} : sum[GATE_W-1:0];
      sat  = over | (|lane_flags) | cov_flag;
    end
  end

endmodule

### src/kalman_tracker_const_velocity_3d.sv
// Top level: 3D constant-velocity Kalman tracker with per-axis lanes.
// Init needs no scale operation; an update or gate that is refused goes straight to the
// result. A quotient is formed one bit per cycle over 96 bits after the product: predict
// and update wait on the covariance chain of 10 or 3 operations, gate on one.
// One item in work at a time; the next is taken while the result waits in the output reg.
// Reset (synchronous): state zero, pp 1.0, pv 0, vv 10.0, registers to defaults.
module kalman_tracker_const_velocity_3d import kt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [95:0]          s_tdata,   // meas_x, meas_y, meas_z
  input  logic [1:0]           s_tuser,   // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [223:0]         m_tdata,   // est_x, est_y, est_z, est_vx, est_vy, est_vz, gate_dist_sq
  output logic [0:0]           m_tuser,   // saturated
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STD_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {T_IDLE, T_START, T_WAIT, T_DONE} state_t;

  state_t                  state;
  logic [DT_W-1:0]         dt;
  logic [STD_W-1:0]        acc_std, noise_std;
  job_t                    job;
  logic                    bypass;
  logic signed [EST_W-1:0] zin [3];
  logic signed [EST_W-1:0] z [3];
  logic signed [EST_W-1:0] pos [3];
  logic signed [EST_W-1:0] vel [3];
  logic [AXES-1:0][COV_W-1:0] terms;
  logic [AXES-1:0]         lane_flags, lane_busy;
  logic signed [COV_W-1:0] pp, pv;
  logic                    cov_flag, cov_busy;
  logic [2*STD_W-1:0]      ms_sq;
  logic signed [COV_W-1:0] r;
  logic signed [DEN_W-1:0] s_val;
  logic                    s_bad;
  cmd_t                    cmd_in;
  logic [GATE_W-1:0]       gate;
  logic                    sat;

  always_comb begin
    ms_sq  = noise_std * noise_std;
    r      = COV_W'((ms_sq + (2*STD_W)'(1 << 15)) >> 16);
    s_val  = DEN_W'(pp) + DEN_W'(r);
    cmd_in = cmd_t'(s_tuser);
    s_bad  = (cmd_in == CMD_UPDATE || cmd_in == CMD_GATE) &&
             (s_val[DEN_W-1] || s_val == '0);
    zin[0] = s_tdata[31:0];
    zin[1] = s_tdata[63:32];
    zin[2] = s_tdata[95:64];
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_axis
      if (g < AXES) begin : g_on
        kt_lane u_lane (
          .clk(clk), .rst(rst), .job(job), .z(z[g]),
          .pos(pos[g]), .vel(vel[g]), .term(terms[g]),
          .flag(lane_flags[g]), .busy(lane_busy[g])
        );
      end else begin : g_off
        assign pos[g] = '0;
        assign vel[g] = '0;
      end
    end
  endgenerate

  kt_cov u_cov (
    .clk(clk), .rst(rst), .job(job), .pp(pp), .pv(pv),
    .flag(cov_flag), .busy(cov_busy)
  );

  kt_merge u_merge (
    .cmd(job.cmd), .bypass(bypass), .terms(terms), .lane_flags(lane_flags),
    .cov_flag(cov_flag), .gate(gate), .sat(sat)
  );

  assign s_tready = (state == T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      m_tvalid  <= 1'b0;
      job.start <= 1'b0;
      bypass    <= 1'b0;
      dt        <= DT_RESET;
      acc_std   <= STD_RESET;
      noise_std <= STD_RESET;
    end else begin
      job.start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP: dt        <= cfg_data[DT_W-1:0];
          REG_ACCEL_STD: acc_std   <= cfg_data;
          REG_MEAS_STD:  noise_std <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        T_IDLE: begin
          if (s_tvalid) begin
            job.cmd <= cmd_in;
            job.t   <= dt;
            job.acc <= acc_std;
            job.r   <= r;
            job.pp  <= pp;
            job.pv  <= pv;
            job.s   <= DEN_W'(s_val);
            for (int i = 0; i < 3; i++) z[i] <= zin[i];
            bypass  <= s_bad;
            if (s_bad) begin
              state <= T_DONE;
            end else begin
              job.start <= 1'b1;
              state     <= T_START;
            end
          end
        end
        T_START: state <= T_WAIT;
        T_WAIT: begin
          if (!(|lane_busy) && !cov_busy) state <= T_DONE;
        end
        T_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {gate, vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
            m_tuser  <= sat;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

### src/kt_checker.sv
// Port-level checks on the tracker's handshakes, bound to the top level.
module kt_checker import kt_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [95:0]          s_tdata,
  input logic [1:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [223:0]         m_tdata,
  input logic [0:0]           m_tuser,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [STD_W-1:0]     cfg_data
);

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without an item in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind kalman_tracker_const_velocity_3d kt_checker u_kt_checker (.*);
